FILE: sv/t_wave_alternans_detector_assert.svh
// Assertion macros shared by the detector RTL.
`ifndef T_WAVE_ALTERNANS_DETECTOR_ASSERT_SVH
`define T_WAVE_ALTERNANS_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TWAD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TWAD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/twad_pkg.sv
package twad_pkg;

    // Beats in one analysis window.
    localparam int WINDOW_BEATS = 4;

    // Field widths fixed by the stream formats.
    localparam int AMP_BITS       = 16;
    localparam int THRESH_BITS    = 7;
    localparam int FIELD_BITS     = 16;
    localparam int OUT_TDATA_BITS = 40;

    // Threshold after reset, in percent, and the percentage scale.
    localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 7'd5;
    localparam logic [THRESH_BITS-1:0] PCT_SCALE       = 7'd100;

endpackage

FILE: sv/t_wave_alternans_detector.sv
// T-wave alternans detector. One T-wave amplitude is taken per transfer on the
// slave stream, one beat per clock cycle unless a full summary path stalls it;
// the beat state (the three previous amplitudes and the saturating beat and
// qualifying-window counters) is updated in the same cycle by a single pass of
// subtract, compare and increment logic. The beat with tlast set closes the
// record; its summary is offered on the master stream (tdata holds detected,
// window_count and alternans_count from bit 0 up, tuser holds insufficient),
// and the state is cleared for the next record. The summary pipeline (count,
// product and output registers) lets beats be accepted while a summary waits,
// until all three hold one. The user must write the threshold in percent on the
// configuration channel only while idle; the block does not enforce it.
`include "t_wave_alternans_detector_assert.svh"

module t_wave_alternans_detector
    import twad_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Beat stream
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [AMP_BITS-1:0]       i_s_axis_tdata,   // t_amplitude
    input  logic                      i_s_axis_tlast,   // last_beat
    // Record summary stream
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // detected [0], window_count [16:1], alternans_count [32:17], zero fill [39:33]
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata,
    output logic [0:0]                o_m_axis_tuser,   // insufficient
    // Threshold write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [THRESH_BITS-1:0]    i_cfg_data
);

    localparam int PROD_BITS = COUNT_BITS + THRESH_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] FULL_PRIOR  = COUNT_BITS'(WINDOW_BEATS - 1);
    localparam logic [COUNT_BITS-1:0] MIN_BEATS   = COUNT_BITS'(WINDOW_BEATS);

    // Configuration register
    logic [THRESH_BITS-1:0] r_threshold;

    // Beat state
    logic [SAMPLE_BITS-1:0] r_prior [3];
    logic [COUNT_BITS-1:0]  r_beat_count;
    logic [COUNT_BITS-1:0]  r_qual_count;

    // Summary pipeline
    logic                   r_s1_valid;
    logic                   r_s1_insuf;
    logic [COUNT_BITS-1:0]  r_s1_windows;
    logic [COUNT_BITS-1:0]  r_s1_qual;
    logic                   r_s2_valid;
    logic                   r_s2_insuf;
    logic [COUNT_BITS-1:0]  r_s2_windows;
    logic [COUNT_BITS-1:0]  r_s2_qual;
    logic [PROD_BITS-1:0]   r_s2_lhs;
    logic [PROD_BITS-1:0]   r_s2_rhs;
    logic                   r_out_valid;
    logic                   r_out_detected;
    logic                   r_out_insuf;
    logic [FIELD_BITS-1:0]  r_out_windows;
    logic [FIELD_BITS-1:0]  r_out_qual;

    logic                   w_out_ready;
    logic                   w_s2_ready;
    logic                   w_s1_ready;
    logic                   w_accept;

    logic [SAMPLE_BITS+AMP_BITS-1:0] w_amp_ext;
    logic [SAMPLE_BITS-1:0] w_cur;
    logic signed [SAMPLE_BITS:0] w_a1, w_a2, w_a3, w_a4;
    logic signed [SAMPLE_BITS:0] w_x12, w_x24, w_x13, w_x34;
    logic [SAMPLE_BITS:0]   w_d12, w_d24, w_d13, w_d34;
    logic                   w_qualifies;
    logic [COUNT_BITS-1:0]  n_beat_count;
    logic [COUNT_BITS-1:0]  n_qual_count;
    logic [COUNT_BITS+FIELD_BITS-1:0] w_windows_ext;
    logic [COUNT_BITS+FIELD_BITS-1:0] w_qual_ext;

    // Handshakes: each summary stage loads when empty or when it moves on.
    assign w_out_ready     = !r_out_valid || i_m_axis_tready;
    assign w_s2_ready      = !r_s2_valid || w_out_ready;
    assign w_s1_ready      = !r_s1_valid || w_s2_ready;
    assign o_s_axis_tready = w_s1_ready;
    assign w_accept        = i_s_axis_tvalid && w_s1_ready;
    assign o_cfg_ready     = 1'b1;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    // Current amplitude brought to the sample width: zero fill or truncation.
    assign w_amp_ext = {{SAMPLE_BITS{1'b0}}, i_s_axis_tdata};
    assign w_cur     = w_amp_ext[SAMPLE_BITS-1:0];

    // Window of four beats, oldest first, sign-extended by one bit.
    assign w_a1 = {r_prior[0][SAMPLE_BITS-1], r_prior[0]};
    assign w_a2 = {r_prior[1][SAMPLE_BITS-1], r_prior[1]};
    assign w_a3 = {r_prior[2][SAMPLE_BITS-1], r_prior[2]};
    assign w_a4 = {w_cur[SAMPLE_BITS-1], w_cur};

    // Absolute differences and the four strict comparisons.
    always_comb begin
        w_x12 = w_a1 - w_a2;
        w_x24 = w_a2 - w_a4;
        w_x13 = w_a1 - w_a3;
        w_x34 = w_a3 - w_a4;
        w_d12 = w_x12[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(0) - w_x12 : w_x12;
        w_d24 = w_x24[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(0) - w_x24 : w_x24;
        w_d13 = w_x13[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(0) - w_x13 : w_x13;
        w_d34 = w_x34[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(0) - w_x34 : w_x34;
        w_qualifies = (w_d12 < w_d13) && (w_d24 < w_d34) &&
                      (w_d24 < w_d13) && (w_d13 < w_d34);
    end

    // Saturating counters after this beat.
    always_comb begin
        n_beat_count = r_beat_count;
        if (r_beat_count != COUNT_MAX) begin
            n_beat_count = r_beat_count + 1'b1;
        end
        n_qual_count = r_qual_count;
        if ((r_beat_count >= FULL_PRIOR) && w_qualifies && (r_qual_count != COUNT_MAX)) begin
            n_qual_count = r_qual_count + 1'b1;
        end
    end

    // Beat state: shift in each beat, clear after the last one of a record.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior[0]   <= '0;
            r_prior[1]   <= '0;
            r_prior[2]   <= '0;
            r_beat_count <= '0;
            r_qual_count <= '0;
        end else if (w_accept) begin
            if (i_s_axis_tlast) begin
                r_prior[0]   <= '0;
                r_prior[1]   <= '0;
                r_prior[2]   <= '0;
                r_beat_count <= '0;
                r_qual_count <= '0;
            end else begin
                r_prior[0]   <= r_prior[1];
                r_prior[1]   <= r_prior[2];
                r_prior[2]   <= w_cur;
                r_beat_count <= n_beat_count;
                r_qual_count <= n_qual_count;
            end
        end
    end

    // Summary valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= w_accept && i_s_axis_tlast;
            end
            if (w_s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // First stage: record counts at the last beat.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_s_axis_tlast) begin
            r_s1_insuf   <= n_beat_count < MIN_BEATS;
            r_s1_windows <= n_beat_count - FULL_PRIOR;
            r_s1_qual    <= n_qual_count;
        end
    end

    // Second stage: both sides of the percentage comparison.
    always_ff @(posedge i_clk) begin
        if (w_s2_ready && r_s1_valid) begin
            r_s2_insuf   <= r_s1_insuf;
            r_s2_windows <= r_s1_windows;
            r_s2_qual    <= r_s1_qual;
            r_s2_lhs     <= PROD_BITS'(r_s1_qual) * PROD_BITS'(PCT_SCALE);
            r_s2_rhs     <= PROD_BITS'(r_s1_windows) * PROD_BITS'(r_threshold);
        end
    end

    // Counts brought to the field width of the summary.
    assign w_windows_ext = {{FIELD_BITS{1'b0}}, r_s2_windows};
    assign w_qual_ext    = {{FIELD_BITS{1'b0}}, r_s2_qual};

    // Output register: decision, and counts forced to zero for a short record.
    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_s2_valid) begin
            r_out_insuf <= r_s2_insuf;
            if (r_s2_insuf) begin
                r_out_detected <= 1'b0;
                r_out_windows  <= '0;
                r_out_qual     <= '0;
            end else begin
                r_out_detected <= r_s2_lhs >= r_s2_rhs;
                r_out_windows  <= w_windows_ext[FIELD_BITS-1:0];
                r_out_qual     <= w_qual_ext[FIELD_BITS-1:0];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_BITS - 2*FIELD_BITS - 1){1'b0}},
                              r_out_qual, r_out_windows, r_out_detected};
    assign o_m_axis_tuser  = r_out_insuf;

    // A short record reports nothing but the insufficient flag.
    `TWAD_ASSERT_IMP(a_short_record_empty, i_clk, i_rst_n,
        r_out_valid && r_out_insuf,
        !r_out_detected && (r_out_windows == '0) && (r_out_qual == '0),
        "short record summary carries counts or detection")

    // The last beat of a record leaves the beat state cleared.
    `TWAD_ASSERT_NXT(a_record_clear, i_clk, i_rst_n,
        w_accept && i_s_axis_tlast,
        (r_beat_count == '0) && (r_qual_count == '0),
        "beat state not cleared after the last beat")

    // A summary held in the first stage is not lost while the next stage is full.
    `TWAD_ASSERT_NXT(a_s1_hold, i_clk, i_rst_n,
        r_s1_valid && !w_s2_ready,
        r_s1_valid,
        "summary dropped from the first stage")

    // The qualifying count never runs ahead of the windows examined before saturation.
    `TWAD_ASSERT_IMP(a_qual_bound, i_clk, i_rst_n,
        (r_beat_count != COUNT_MAX) && (r_beat_count >= FULL_PRIOR),
        r_qual_count <= (r_beat_count - FULL_PRIOR),
        "qualifying count exceeds windows examined")

endmodule

FILE: sim/alternans_summary_checker.sv
`timescale 1ns / 1ps

// Watches the beat, summary and threshold channels of the detector. It keeps its
// own copy of the beat history, the record counters and the threshold, works out
// the summary that each closing beat must produce, and compares every summary
// transfer with the oldest one waiting.
module alternans_summary_checker
    import twad_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Beat channel
    input  logic                      i_beat_valid,
    input  logic                      i_beat_ready,
    input  logic [AMP_BITS-1:0]       i_beat_amp,
    input  logic                      i_beat_last,
    // Summary channel
    input  logic                      i_sum_valid,
    input  logic                      i_sum_ready,
    // detected [0], window_count [16:1], alternans_count [32:17], zero fill [39:33]
    input  logic [OUT_TDATA_BITS-1:0] i_sum_tdata,
    input  logic [0:0]                i_sum_tuser,      // insufficient
    // Threshold channel
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [THRESH_BITS-1:0]    i_cfg_data,
    output int                        o_pending,
    output int                        o_fail_count
);

    localparam logic [FIELD_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                  detected;
        logic                  insufficient;
        logic [FIELD_BITS-1:0] window_count;
        logic [FIELD_BITS-1:0] alternans_count;
    } t_summary;

    t_summary                   expected_summaries[$];
    t_summary                   want;
    logic signed [AMP_BITS-1:0] history [3];
    logic [FIELD_BITS-1:0]      beats;
    logic [FIELD_BITS-1:0]      hits;
    logic [THRESH_BITS-1:0]     threshold;
    int                         mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    initial o_pending = 0;

    // Distance between two amplitudes, one bit wider than a sample.
    function automatic logic [AMP_BITS:0] amp_distance(
        input logic signed [AMP_BITS-1:0] a,
        input logic signed [AMP_BITS-1:0] b
    );
        logic signed [AMP_BITS:0] diff;
        diff = a - b;
        return (diff < 0) ? -diff : diff;
    endfunction

    // Starts a fresh record: no history and both counters at zero.
    task automatic clear_record();
        history[0] = '0;
        history[1] = '0;
        history[2] = '0;
        beats      = '0;
        hits       = '0;
    endtask

    // Advances the record by one beat and queues the summary when the beat
    // closes the record.
    task automatic predict_beat(
        input logic signed [AMP_BITS-1:0] amp,
        input logic                       last
    );
        logic [AMP_BITS:0]     d12, d24, d13, d34;
        logic [FIELD_BITS-1:0] windows;
        logic [31:0]           scaled_hits, needed;
        t_summary              s;
        // A window exists once three earlier beats are held.
        if (beats >= WINDOW_BEATS - 1) begin
            d12 = amp_distance(history[0], history[1]);
            d24 = amp_distance(history[1], amp);
            d13 = amp_distance(history[0], history[2]);
            d34 = amp_distance(history[2], amp);
            if (d12 < d13 && d24 < d34 && d24 < d13 && d13 < d34 && hits != COUNT_MAX) begin
                hits = hits + 1'b1;
            end
        end
        history[0] = history[1];
        history[1] = history[2];
        history[2] = amp;
        if (beats != COUNT_MAX) begin
            beats = beats + 1'b1;
        end
        if (last) begin
            s = '0;
            if (beats < WINDOW_BEATS) begin
                s.insufficient = 1'b1;
            end else begin
                windows           = beats - (WINDOW_BEATS - 1);
                scaled_hits       = hits * PCT_SCALE;
                needed            = threshold * windows;
                s.detected        = (scaled_hits >= needed);
                s.window_count    = windows;
                s.alternans_count = hits;
            end
            expected_summaries = {expected_summaries, s};
            clear_record();
        end
    endtask

    // Transfers are taken from the values held just before each rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            threshold = THRESHOLD_RESET;
            clear_record();
            expected_summaries.delete();
        end else begin
            // A summary can never belong to a beat taken in the same cycle.
            if (i_sum_valid && i_sum_ready) begin
                if (expected_summaries.size() == 0) begin
                    $error("summary transfer with no summary expected");
                    mismatch_count++;
                end else begin
                    want = expected_summaries.pop_front();
                    if (i_sum_tdata[0] !== want.detected) begin
                        $error("detected: expected %0d, actual %0d",
                               want.detected, i_sum_tdata[0]);
                        mismatch_count++;
                    end
                    if (i_sum_tuser[0] !== want.insufficient) begin
                        $error("insufficient: expected %0d, actual %0d",
                               want.insufficient, i_sum_tuser[0]);
                        mismatch_count++;
                    end
                    if (i_sum_tdata[16:1] !== want.window_count) begin
                        $error("window_count: expected %0d, actual %0d",
                               want.window_count, i_sum_tdata[16:1]);
                        mismatch_count++;
                    end
                    if (i_sum_tdata[32:17] !== want.alternans_count) begin
                        $error("alternans_count: expected %0d, actual %0d",
                               want.alternans_count, i_sum_tdata[32:17]);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                threshold = i_cfg_data;
            end
            if (i_beat_valid && i_beat_ready) begin
                predict_beat(i_beat_amp, i_beat_last);
            end
        end
        o_pending <= expected_summaries.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import twad_pkg::*;

    localparam int CYCLE_LIMIT     = 400_000;
    localparam int RANDOM_BEATS    = 450;
    localparam int SETTLE_CYCLES   = 10;
    localparam int RX_HOLD_CYCLES  = 200;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      beat_valid;
    logic                      beat_ready;
    logic [AMP_BITS-1:0]       beat_amp;
    logic                      beat_last;
    logic                      sum_valid;
    logic                      sum_ready;
    logic [OUT_TDATA_BITS-1:0] sum_tdata;
    logic [0:0]                sum_tuser;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [THRESH_BITS-1:0]    cfg_data;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int random_count = 0;
    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    bit rx_hold_req = 1'b0;

    always #5 clk = ~clk;

    t_wave_alternans_detector dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (beat_valid),
        .o_s_axis_tready (beat_ready),
        .i_s_axis_tdata  (beat_amp),
        .i_s_axis_tlast  (beat_last),
        .o_m_axis_tvalid (sum_valid),
        .i_m_axis_tready (sum_ready),
        .o_m_axis_tdata  (sum_tdata),
        .o_m_axis_tuser  (sum_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    alternans_summary_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_beat_valid (beat_valid),
        .i_beat_ready (beat_ready),
        .i_beat_amp   (beat_amp),
        .i_beat_last  (beat_last),
        .i_sum_valid  (sum_valid),
        .i_sum_ready  (sum_ready),
        .i_sum_tdata  (sum_tdata),
        .i_sum_tuser  (sum_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Guard against a hung run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Summary receiver: random stalls, and a long hold-off when requested.
    initial begin
        int gap;
        sum_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!rst_n) begin
                sum_ready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                sum_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 14);
                sum_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end else begin
                sum_ready <= 1'b1;
            end
        end
    end

    // Offers one beat, after a random gap when idling is on, and waits for
    // its transfer.
    task automatic send_beat(input logic [AMP_BITS-1:0] amp, input logic last);
        int gap;
        @(negedge clk);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            beat_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        beat_valid <= 1'b1;
        beat_amp   <= amp;
        beat_last  <= last;
        do @(posedge clk); while (!beat_ready);
    endtask

    // Stops offering beats until every summary has come, then lets the
    // pipeline settle.
    task automatic wait_for_summaries();
        @(negedge clk);
        beat_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes the threshold once the block is idle.
    task automatic write_threshold(input logic [THRESH_BITS-1:0] value);
        wait_for_summaries();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Four beats whose single window qualifies, with the given offset and step.
    task automatic send_alternans_block(input int base, input int step, input logic last);
        send_beat(AMP_BITS'(base), 1'b0);
        send_beat(AMP_BITS'(base + step), 1'b0);
        send_beat(AMP_BITS'(base + 10 * step), 1'b0);
        send_beat(AMP_BITS'(base - step), last);
    endtask

    // One random record: alternans-shaped blocks, full-range noise, or small
    // values that give many ties.
    task automatic send_random_record();
        int kind, len, blocks;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            blocks = $urandom_range(1, 3);
            for (int b = 0; b < blocks; b++) begin
                send_alternans_block($urandom_range(0, 5900) - 2900, $urandom_range(1, 2900),
                                     b == blocks - 1);
            end
            random_count += 4 * blocks;
        end else begin
            len = $urandom_range(1, 10);
            for (int n = 0; n < len; n++) begin
                if (kind >= 8) begin
                    send_beat(AMP_BITS'($urandom_range(0, 16) - 8), n == len - 1);
                end else begin
                    send_beat(AMP_BITS'($urandom_range(0, 65535)), n == len - 1);
                end
            end
            random_count += len;
        end
    endtask

    // Stimulus and verdict.
    initial begin
        rst_n      = 1'b0;
        beat_valid = 1'b0;
        beat_amp   = '0;
        beat_last  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Short records are flagged as insufficient, extremes included.
        send_beat(16'h0000, 1'b1);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h0000, 1'b1);
        // A qualifying window, then one spanning the full amplitude range.
        send_alternans_block(0, 1, 1'b1);
        send_beat(16'h7FFE, 1'b0);
        send_beat(16'h7FFE, 1'b0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h7FFF, 1'b1);
        // Equal amplitudes fail every strict comparison.
        repeat (3) send_beat(16'h0000, 1'b0);
        send_beat(16'h0000, 1'b1);
        // A zero threshold detects any sufficient record.
        write_threshold(7'd0);
        repeat (3) send_beat(16'h0000, 1'b0);
        send_beat(16'h0000, 1'b1);
        // Above one hundred percent nothing is detected; at exactly one
        // hundred a fully qualifying record is.
        write_threshold(7'd127);
        send_alternans_block(-100, 7, 1'b1);
        write_threshold(7'd100);
        send_alternans_block(200, 3, 1'b1);

        // Random records over several thresholds.
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int phase = 0; phase < 5; phase++) begin
            write_threshold(THRESH_BITS'($urandom_range(0, 127)));
            if (phase == 2) begin
                // The receiver holds off while single-beat records keep coming,
                // so the summary path fills and the beat input stalls.
                rx_hold_req = 1'b1;
                for (int n = 0; n < 40; n++) begin
                    send_beat(AMP_BITS'($urandom_range(0, 65535)), 1'b1);
                end
                random_count += 40;
            end
            if (phase == 4) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            while (random_count < (phase + 1) * RANDOM_BEATS / 5) begin
                send_random_record();
            end
        end

        wait_for_summaries();
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: t_wave_alternans_detector.f
+incdir+sv
sv/twad_pkg.sv
sv/t_wave_alternans_detector.sv
sim/alternans_summary_checker.sv
sim/tb.sv
